// ===== hdl/lab_pkg.sv =====
`timescale 1ns / 1ps

package lab_pkg;

  // Default sizing
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_EXP_DEF   = 15;

  // Width of the divider datapath
  localparam int DIV_W = 64;

  // Action codes
  localparam logic [2:0] ACT_LOAD   = 3'd0;
  localparam logic [2:0] ACT_ADD    = 3'd1;
  localparam logic [2:0] ACT_SUB    = 3'd2;
  localparam logic [2:0] ACT_MUL    = 3'd3;
  localparam logic [2:0] ACT_DIV    = 3'd4;
  localparam logic [2:0] ACT_POW    = 3'd5;
  localparam logic [2:0] ACT_REBASE = 3'd6;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BASE_ONE    = 3'd1;
  localparam logic [2:0] ST_BASE_NONPOS = 3'd2;
  localparam logic [2:0] ST_NUM_NONPOS  = 3'd3;
  localparam logic [2:0] ST_DIV_ZERO    = 3'd4;
  localparam logic [2:0] ST_SAT         = 3'd5;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } sat_res_t;

  // Apply a sign to a magnitude and clamp to the 32-bit signed range
  function automatic sat_res_t from_mag(input logic neg, input logic [DIV_W-1:0] mag);
    sat_res_t res;
    res.sat = 1'b0;
    if (!neg) begin
      if (mag > DIV_W'(32'h7FFF_FFFF)) begin
        res.sat = 1'b1;
        res.val = 32'h7FFF_FFFF;
      end else begin
        res.val = mag[31:0];
      end
    end else begin
      if (mag > DIV_W'(32'h8000_0000)) begin
        res.sat = 1'b1;
        res.val = 32'h8000_0000;
      end else begin
        res.val = 32'd0 - mag[31:0];
      end
    end
    return res;
  endfunction

endpackage

// ===== hdl/lab_div.sv =====
`timescale 1ns / 1ps

module lab_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lab_pkg::DIV_W-1:0]   dividend,
  input  logic [lab_pkg::DIV_W-1:0]   divisor,
  output logic                        done,
  output logic [lab_pkg::DIV_W-1:0]   quotient
);

  localparam int W    = lab_pkg::DIV_W;
  localparam int CNTW = $clog2(W + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [W:0]      rem;
  logic [W-1:0]    dvd;
  logic [W-1:0]    dvs;
  logic [W-1:0]    quo;
  logic [W:0]      rem_sh;
  logic [W+1:0]    diff;
  logic            ge;

  // One restoring step: shift in the next dividend bit, trial subtract
  assign rem_sh   = {rem[W-1:0], dvd[W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b0, dvs};
  assign ge       = !diff[W+1];
  assign quotient = quo;

  // Advance one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(W);
        rem  <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
        quo  <= '0;
      end else if (busy) begin
        rem <= ge ? diff[W:0] : rem_sh;
        dvd <= {dvd[W-2:0], 1'b0};
        quo <= {quo[W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/log_any_base_accumulator.sv =====
`timescale 1ns / 1ps

// Log value accumulator with change of base, signed fixed point words.
// Input channel (in_valid/in_ready) carries one request: an action code
// with number_in, base_in, operand_value and exponent. Output channel
// (out_valid/out_ready) returns one result per request: value_out, the
// stored log value after the request, and a status code.
// One request is worked at a time; in_ready is high only while idle.
// Each request is worked by one shared multiplier and a bit-serial
// divider: add/subtract in the dispatch step; multiply with one product;
// divide with one division; power with one product per extra factor;
// load and rebase run two logarithms (up to 30 normalizing shifts and
// 30 squarings each) and a 64-step division.
// Reset clears the stored number, base and log value to zero and
// empties the output register. A finished result waits in the output
// register while the receiver stalls; the next request can be taken in
// meanwhile, and its result is held until the output register frees.
module log_any_base_accumulator #(
  parameter int FRAC_BITS    = lab_pkg::FRAC_BITS_DEF,
  parameter int MAX_EXPONENT = lab_pkg::MAX_EXP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [31:0] number_in,
  input  logic [31:0] base_in,
  input  logic [31:0] operand_value,
  input  logic [3:0]  exponent,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value_out,
  output logic [2:0]  status
);

  localparam int W = lab_pkg::DIV_W;
  localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);
  localparam logic [W-1:0] HALF_LSB = W'(64'd1 << (FRAC_BITS - 1));

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_NORM   = 4'd2;
  localparam logic [3:0] S_SQR    = 4'd3;
  localparam logic [3:0] S_LOGFIN = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_DIVFIN = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_MULRND = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]  state;
  logic [2:0]  act_r;
  logic [31:0] num_r;
  logic [31:0] base_r;
  logic [31:0] opv_r;
  logic [3:0]  e_r;
  logic [31:0] stored_number;
  logic [31:0] stored_base;
  logic [31:0] log_value;
  logic [31:0] m;
  logic [4:0]  p;
  logic [29:0] frac;
  logic [5:0]  cnt;
  logic        phase;
  logic [37:0] ln_r;
  logic [31:0] r_acc;
  logic [31:0] mop;
  logic [65:0] prod;
  logic        sat_acc;
  logic        neg_r;
  logic [31:0] res_val;
  logic [2:0]  res_st;

  logic               div_start;
  logic [W-1:0]       div_num;
  logic [W-1:0]       div_den;
  logic               div_done;
  logic [W-1:0]       div_quo;

  assign in_ready = (state == S_IDLE);

  // Shared multiplier: squares the mantissa or forms a log product
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  assign mul_a = (state == S_SQR) ? $signed({1'b0, m}) : $signed({r_acc[31], r_acc});
  assign mul_b = (state == S_SQR) ? $signed({1'b0, m}) : $signed({mop[31], mop});
  assign mul_p = mul_a * mul_b;

  logic [31:0] sq_t;
  assign sq_t = mul_p[61:30];

  // Round a registered product to nearest on the magnitude
  logic        pneg;
  logic [65:0] pmag;
  logic [W-1:0] rnd;
  lab_pkg::sat_res_t mul_res;
  always_comb begin
    pneg    = prod[65];
    pmag    = pneg ? (66'd0 - prod) : prod;
    rnd     = (pmag[W-1:0] + HALF_LSB) >> FRAC_BITS;
    mul_res = lab_pkg::from_mag(pneg, rnd);
  end

  // Logarithm just finished: integer part from the top bit position
  logic [7:0]  ip;
  logic [37:0] lg_cur;
  logic [37:0] ln_mag;
  logic [37:0] lb_mag;
  assign ip     = {3'b0, p} - 8'(FRAC_BITS);
  assign lg_cur = {ip, frac};
  assign ln_mag = ln_r[37] ? (38'd0 - ln_r) : ln_r;
  assign lb_mag = lg_cur[37] ? (38'd0 - lg_cur) : lg_cur;

  // Magnitudes for the divide action
  logic [31:0] lv_mag;
  logic [31:0] ov_mag;
  assign lv_mag = log_value[31] ? (32'd0 - log_value) : log_value;
  assign ov_mag = opv_r[31] ? (32'd0 - opv_r) : opv_r;

  // Add or subtract with clamping
  logic [32:0] sum;
  assign sum = (act_r == lab_pkg::ACT_ADD) ? ({log_value[31], log_value} + {opv_r[31], opv_r})
                                           : ({log_value[31], log_value} - {opv_r[31], opv_r});

  // Load and rebase checks
  logic [31:0] nsrc;
  assign nsrc = (act_r == lab_pkg::ACT_LOAD) ? num_r : stored_number;

  // Effective power after clamping
  logic [5:0] e_eff;
  assign e_eff = (int'(e_r) > MAX_EXPONENT) ? 6'(MAX_EXPONENT) : {2'b0, e_r};

  lab_pkg::sat_res_t div_res;
  assign div_res = lab_pkg::from_mag(neg_r, div_quo);

  // Divider request
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state == S_LOGFIN && phase && lg_cur != '0) begin
      div_start = 1'b1;
      div_num   = ({26'd0, ln_mag} << FRAC_BITS) + {27'd0, lb_mag[37:1]};
      div_den   = {26'd0, lb_mag};
    end else if (state == S_DISP && act_r == lab_pkg::ACT_DIV && opv_r != '0) begin
      div_start = 1'b1;
      div_num   = ({32'd0, lv_mag} << FRAC_BITS) + {33'd0, ov_mag[31:1]};
      div_den   = {32'd0, ov_mag};
    end
  end

  lab_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      stored_number <= '0;
      stored_base   <= '0;
      log_value     <= '0;
    end else begin
      // Drop the taken result unless a new one replaces it this cycle
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act_r  <= action;
            num_r  <= number_in;
            base_r <= base_in;
            opv_r  <= operand_value;
            e_r    <= exponent;
            state  <= S_DISP;
          end
        end
        S_DISP: begin
          res_val <= log_value;
          res_st  <= lab_pkg::ST_OK;
          state   <= S_DONE;
          case (act_r)
            lab_pkg::ACT_LOAD, lab_pkg::ACT_REBASE: begin
              if (base_r == ONE_FX) begin
                res_st <= lab_pkg::ST_BASE_ONE;
              end else if ($signed(base_r) <= 0) begin
                res_st <= lab_pkg::ST_BASE_NONPOS;
              end else if ($signed(nsrc) <= 0) begin
                res_st <= lab_pkg::ST_NUM_NONPOS;
              end else begin
                num_r <= nsrc;
                m     <= nsrc;
                p     <= 5'd30;
                phase <= 1'b0;
                state <= S_NORM;
              end
            end
            lab_pkg::ACT_ADD, lab_pkg::ACT_SUB: begin
              if (sum[32] != sum[31]) begin
                log_value <= sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                res_val   <= sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                res_st    <= lab_pkg::ST_SAT;
              end else begin
                log_value <= sum[31:0];
                res_val   <= sum[31:0];
              end
            end
            lab_pkg::ACT_MUL: begin
              r_acc   <= log_value;
              mop     <= opv_r;
              cnt     <= 6'd1;
              sat_acc <= 1'b0;
              state   <= S_MUL;
            end
            lab_pkg::ACT_DIV: begin
              if (opv_r == '0) begin
                res_st <= lab_pkg::ST_DIV_ZERO;
              end else begin
                neg_r <= log_value[31] ^ opv_r[31];
                state <= S_DIV;
              end
            end
            lab_pkg::ACT_POW: begin
              if (e_eff == '0) begin
                log_value <= ONE_FX;
                res_val   <= ONE_FX;
              end else if (e_eff != 6'd1) begin
                r_acc   <= log_value;
                mop     <= log_value;
                cnt     <= e_eff - 6'd1;
                sat_acc <= 1'b0;
                state   <= S_MUL;
              end
            end
            default: begin
            end
          endcase
        end
        S_NORM: begin
          // Shift the top set bit up to bit 30
          if (!m[30]) begin
            m <= {m[30:0], 1'b0};
            p <= p - 5'd1;
          end else begin
            cnt   <= 6'd30;
            state <= S_SQR;
          end
        end
        S_SQR: begin
          // Square the mantissa, take one fraction bit
          if (sq_t[31]) begin
            m <= {1'b0, sq_t[31:1]};
          end else begin
            m <= sq_t;
          end
          frac <= {frac[28:0], sq_t[31]};
          cnt  <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_LOGFIN;
          end
        end
        S_LOGFIN: begin
          if (!phase) begin
            ln_r  <= lg_cur;
            m     <= base_r;
            p     <= 5'd30;
            phase <= 1'b1;
            state <= S_NORM;
          end else if (lg_cur == '0) begin
            res_st <= lab_pkg::ST_BASE_ONE;
            state  <= S_DONE;
          end else begin
            stored_number <= num_r;
            stored_base   <= base_r;
            neg_r         <= ln_r[37] ^ lg_cur[37];
            state         <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DIVFIN;
          end
        end
        S_DIVFIN: begin
          log_value <= div_res.val;
          res_val   <= div_res.val;
          res_st    <= div_res.sat ? lab_pkg::ST_SAT : lab_pkg::ST_OK;
          state     <= S_DONE;
        end
        S_MUL: begin
          prod  <= mul_p;
          state <= S_MULRND;
        end
        S_MULRND: begin
          r_acc <= mul_res.val;
          cnt   <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            log_value <= mul_res.val;
            res_val   <= mul_res.val;
            res_st    <= (sat_acc || mul_res.sat) ? lab_pkg::ST_SAT : lab_pkg::ST_OK;
            state     <= S_DONE;
          end else begin
            sat_acc <= sat_acc | mul_res.sat;
            state   <= S_MUL;
          end
        end
        S_DONE: begin
          // Hold the result until the output register frees
          if (!out_valid || out_ready) begin
            value_out <= res_val;
            status    <= res_st;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DISP))
    else $error("accepted request not dispatched");

  a_done_emits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("finished result not presented");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= lab_pkg::ST_SAT))
    else $error("status code out of range");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == S_DIV))
    else $error("divider started outside a division");

  a_sqr_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQR) |-> (cnt != 6'd0 && cnt <= 6'd30))
    else $error("squaring count out of range");
`endif

endmodule
